[sv/substring_first_match_search_top_defines.svh]
// assertion macros shared by the substring search block
`ifndef SUBSTRING_FIRST_MATCH_SEARCH_TOP_DEFINES_SVH
`define SUBSTRING_FIRST_MATCH_SEARCH_TOP_DEFINES_SVH

// property that must hold in every cycle outside reset
`define SFMS_CHECK(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("sfms check failed");

// property whose consequence must hold in the cycle after its trigger
`define SFMS_CHECK_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sfms sequence check failed");

`endif

[sv/sfms_pkg.sv]
// shared constants, request and status codes, and cell control type
package sfms_pkg;

	localparam int MAX_NEEDLE = 64;
	localparam int INDEX_BITS = 16;
	localparam int LEN_W      = $clog2(MAX_NEEDLE + 1);
	localparam int POS_W      = INDEX_BITS + 1;
	localparam int IDX_W      = 16;
	localparam int DIFF_W     = (POS_W > LEN_W) ?
		((POS_W > IDX_W) ? POS_W : IDX_W) :
		((LEN_W > IDX_W) ? LEN_W : IDX_W);

	typedef enum logic [1:0] {
		REQ_APPEND = 2'd0,
		REQ_HAY    = 2'd1,
		REQ_FINISH = 2'd2
	} req_t;

	typedef enum logic [1:0] {
		STAT_FOUND     = 2'd0,
		STAT_NOT_FOUND = 2'd1,
		STAT_EMPTY     = 2'd2,
		STAT_OVERFLOW  = 2'd3
	} status_t;

	typedef struct packed {
		logic       clear;
		logic       append;
		logic       shift;
		logic [7:0] ch;
	} cell_ctrl_t;

endpackage

[sv/sfms_cell.sv]
// one needle position: stored byte, length mark, partial match bit
module sfms_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  sfms_pkg::cell_ctrl_t ctrl,
	input  logic                prev_pm,
	input  logic                prev_valid,
	input  logic                next_valid,
	output logic                pm,
	output logic                valid,
	output logic                hit
);
	import sfms_pkg::*;

	logic [7:0] byte_q;
	logic       valid_q;
	logic       pm_q;
	logic       hit_q;
	logic       pm_next;

	// partial match extends from the left neighbor when this byte matches
	assign pm_next = prev_pm & valid_q & (byte_q == ctrl.ch);

	// needle byte lands in the first free position
	always_ff @(posedge clk) begin
		if (ctrl.append && prev_valid && !valid_q) begin
			byte_q <= ctrl.ch;
		end
	end

	// length mark, partial match and end-of-needle hit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pm_q    <= 1'b0;
			hit_q   <= 1'b0;
		end else if (ctrl.clear) begin
			valid_q <= 1'b0;
			pm_q    <= 1'b0;
			hit_q   <= 1'b0;
		end else begin
			if (ctrl.append) begin
				valid_q <= prev_valid;
			end
			if (ctrl.shift) begin
				pm_q  <= pm_next;
				hit_q <= pm_next & ~next_valid;
			end else begin
				hit_q <= 1'b0;
			end
		end
	end

	assign pm    = pm_q;
	assign valid = valid_q;
	assign hit   = hit_q;

endmodule

[sv/sfms_chain.sv]
// row of needle cells with partial match bits passed left to right
module sfms_chain (
	input  logic                              clk,
	input  logic                              arst_n,
	input  sfms_pkg::cell_ctrl_t              ctrl,
	output logic [sfms_pkg::MAX_NEEDLE-1:0]   valid_vec,
	output logic                              any_hit
);
	import sfms_pkg::*;

	logic [MAX_NEEDLE-1:0] pm_vec;
	logic [MAX_NEEDLE-1:0] hit_vec;
	logic [MAX_NEEDLE-1:0] pm_in;
	logic [MAX_NEEDLE-1:0] valid_in;
	logic [MAX_NEEDLE-1:0] valid_nxt;

	// neighbor links; the first cell always starts a match
	always_comb begin
		pm_in    = {pm_vec[MAX_NEEDLE-2:0], 1'b1};
		valid_in = {valid_vec[MAX_NEEDLE-2:0], 1'b1};
		valid_nxt = {1'b0, valid_vec[MAX_NEEDLE-1:1]};
	end

	for (genvar k = 0; k < MAX_NEEDLE; k++) begin : g_cell
		sfms_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.prev_pm    (pm_in[k]),
			.prev_valid (valid_in[k]),
			.next_valid (valid_nxt[k]),
			.pm         (pm_vec[k]),
			.valid      (valid_vec[k]),
			.hit        (hit_vec[k])
		);
	end

	// only the last needle cell can report a full match
	assign any_hit = |hit_vec;

endmodule

[sv/substring_first_match_search_top.sv]
// top level of the streamed first-occurrence substring search
// Usage:
//   Input channel (in_valid/in_ready) carries req_type and char_byte. Append
//   beats build the needle one byte at a time, haystack beats stream text one
//   byte per beat, a finish beat asks for the result and clears all state.
//   Output channel (out_valid/out_ready) carries status and match_index; one
//   beat per finish, in order.
// Timing:
//   A new beat can be taken every cycle while in_ready is high. A result
//   is registered and appears on the output in the cycle after its finish
//   beat. The cell row registers a full needle match in the cycle after the
//   completing haystack byte; a finish right behind that byte folds it in.
// Stall:
//   The result sits in an output register. in_ready drops only while that
//   register holds an untaken result and out_ready is low.
// Reset:
//   arst_n clears needle length, partial matches, position, match and
//   overflow flags and the output valid. Needle bytes need no clearing.
`include "substring_first_match_search_top_defines.svh"

module substring_first_match_search_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   req_type,
	input  logic [7:0]                   char_byte,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [1:0]                   status,
	output logic [sfms_pkg::IDX_W-1:0]   match_index
);
	import sfms_pkg::*;

	logic                  fire;
	logic                  full;
	logic [MAX_NEEDLE-1:0] valid_vec;
	logic                  any_hit;
	cell_ctrl_t            ctrl;

	logic [LEN_W-1:0]      len_q;
	logic [POS_W-1:0]      pos_q;
	logic                  found_q;
	logic [IDX_W-1:0]      found_idx_q;
	logic                  ovf_q;
	logic                  out_valid_q;
	logic [1:0]            status_q;
	logic [IDX_W-1:0]      match_index_q;

	logic [DIFF_W-1:0]     diff;
	logic [IDX_W-1:0]      hit_idx;
	logic                  eff_found;
	logic [IDX_W-1:0]      eff_idx;
	status_t               res_status;
	logic [IDX_W-1:0]      res_idx;
	logic                  is_append;
	logic                  is_hay;
	logic                  is_finish;

	assign in_ready = !out_valid_q || out_ready;
	assign fire     = in_valid && in_ready;
	assign full     = valid_vec[MAX_NEEDLE-1];

	// request decode
	always_comb begin
		is_append = 1'b0;
		is_hay    = 1'b0;
		is_finish = 1'b0;
		unique case (req_type)
			REQ_APPEND: is_append = fire;
			REQ_HAY:    is_hay    = fire;
			REQ_FINISH: is_finish = fire;
			default:    ;
		endcase
	end

	// cell row control
	always_comb begin
		ctrl.clear  = is_finish;
		ctrl.append = is_append && (pos_q == '0) && !full;
		ctrl.shift  = is_hay && !pos_q[INDEX_BITS];
		ctrl.ch     = char_byte;
	end

	sfms_chain u_chain (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.valid_vec (valid_vec),
		.any_hit   (any_hit)
	);

	// match start = position after the byte minus needle length
	assign diff    = DIFF_W'(pos_q) - DIFF_W'(len_q);
	assign hit_idx = diff[IDX_W-1:0];

	assign eff_found = found_q || any_hit;
	assign eff_idx   = found_q ? found_idx_q : hit_idx;

	// result priority: overflow, empty, found, not found
	always_comb begin
		res_idx = '0;
		priority if (ovf_q) begin
			res_status = STAT_OVERFLOW;
		end else if (len_q == '0 || pos_q == '0) begin
			res_status = STAT_EMPTY;
		end else if (eff_found) begin
			res_status = STAT_FOUND;
			res_idx    = eff_idx;
		end else begin
			res_status = STAT_NOT_FOUND;
		end
	end

	// search state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			pos_q       <= '0;
			found_q     <= 1'b0;
			found_idx_q <= '0;
			ovf_q       <= 1'b0;
		end else if (is_finish) begin
			len_q       <= '0;
			pos_q       <= '0;
			found_q     <= 1'b0;
			found_idx_q <= '0;
			ovf_q       <= 1'b0;
		end else begin
			if (any_hit && !found_q) begin
				found_q     <= 1'b1;
				found_idx_q <= hit_idx;
			end
			if (is_append && pos_q == '0) begin
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					len_q <= len_q + 1'b1;
				end
			end
			if (is_hay) begin
				if (pos_q[INDEX_BITS]) begin
					ovf_q <= 1'b1;
				end else begin
					pos_q <= pos_q + 1'b1;
				end
			end
		end
	end

	// output beat control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (is_finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output beat payload
	always_ff @(posedge clk) begin
		if (is_finish) begin
			status_q      <= res_status;
			match_index_q <= res_idx;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign match_index = match_index_q;

	// needle length marks are a contiguous run from the first cell
	`SFMS_CHECK(a_valid_thermo, ((valid_vec & (valid_vec + 1'b1)) == '0))
	`SFMS_CHECK(a_len_matches_cells, ($countones(valid_vec) == int'(len_q)))
	`SFMS_CHECK(a_hit_needs_needle, (any_hit |-> (len_q != '0 && pos_q != '0)))
	`SFMS_CHECK(a_found_needs_text, (found_q |-> (len_q != '0 && pos_q != '0)))
	`SFMS_CHECK_NEXT(a_finish_clears, is_finish, out_valid_q && !found_q && len_q == '0)

endmodule

[tb/tb_substring_first_match_search_top.sv]
// self-checking testbench for the streamed first-occurrence substring search
`timescale 1ns / 1ps

module tb_substring_first_match_search_top;
	import sfms_pkg::*;

	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int unsigned POS_LIMIT = 1 << INDEX_BITS;
	localparam int QUIET_LIMIT = 3000;
	localparam int RANDOM_BEATS = 1500;
	localparam int CALM_TAIL = 200;
	localparam int HOLD_CYCLES = 400;
	localparam int HOLD_AFTER = 25;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] ch;
	} beat_t;

	typedef struct packed {
		status_t          st;
		logic [IDX_W-1:0] idx;
	} search_result_t;

	typedef logic [7:0] text_t[$];

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] req_type = REQ_APPEND;
	logic [7:0] char_byte = 8'h00;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] status;
	logic [IDX_W-1:0] match_index;

	// beats waiting to be sent and search results still owed by the block
	beat_t stim_beats[$];
	search_result_t want_results[$];
	int made_beats = 0;

	// shadow copy of the search state
	bit [7:0] ndl[MAX_NEEDLE];
	int unsigned ndl_len = 0;
	logic [MAX_NEEDLE-1:0] partial = '0;
	int unsigned hay_pos = 0;
	bit hit = 1'b0;
	int unsigned hit_at = 0;
	bit ovf_seen = 1'b0;

	// sender and receiver bookkeeping
	beat_t cur;
	int beats_in = 0;
	int gap_left = 0;
	int idle_pct = 0;
	bit calm = 1'b0;
	int results_seen = 0;
	int stall_left = 0;
	int stall_pct = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	int mon_cycles = 0;
	int n_err = 0;
	int quiet = 0;

	substring_first_match_search_top i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.char_byte   (char_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.match_index (match_index)
	);

	always #5 clk = ~clk;

	function automatic int pick_idle_pct();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 8;
			default: return 30;
		endcase
	endfunction

	function automatic logic [7:0] pick_char(input logic [7:0] alpha[4], input int n,
			input bit wild);
		if (wild)
			return 8'($urandom);
		return alpha[$urandom_range(0, n - 1)];
	endfunction

	task automatic put(input logic [1:0] kind, input logic [7:0] ch);
		stim_beats.push_back('{kind: kind, ch: ch});
		if (kind != REQ_UNUSED)
			made_beats++;
	endtask

	// advance the shadow search by one accepted beat
	task automatic search_step(input beat_t b);
		logic [MAX_NEEDLE-1:0] nxt;
		search_result_t r;
		case (b.kind)
			REQ_APPEND: begin
				// needle is locked once the haystack has started
				if (hay_pos == 0) begin
					if (ndl_len >= MAX_NEEDLE) begin
						ovf_seen = 1'b1;
					end else begin
						ndl[ndl_len] = b.ch;
						ndl_len++;
					end
				end
			end
			REQ_HAY: begin
				if (hay_pos >= POS_LIMIT) begin
					ovf_seen = 1'b1;
				end else begin
					nxt = {partial[MAX_NEEDLE-2:0], 1'b1};
					for (int k = 0; k < MAX_NEEDLE; k++)
						if (k >= ndl_len || ndl[k] != b.ch)
							nxt[k] = 1'b0;
					partial = nxt;
					if (ndl_len > 0 && !hit && partial[ndl_len-1]) begin
						hit = 1'b1;
						hit_at = hay_pos - (ndl_len - 1);
					end
					hay_pos++;
				end
			end
			REQ_FINISH: begin
				r.idx = '0;
				if (ovf_seen)
					r.st = STAT_OVERFLOW;
				else if (ndl_len == 0 || hay_pos == 0)
					r.st = STAT_EMPTY;
				else if (hit) begin
					r.st = STAT_FOUND;
					r.idx = hit_at[IDX_W-1:0];
				end else
					r.st = STAT_NOT_FOUND;
				want_results.push_back(r);
				ndl_len = 0;
				partial = '0;
				hay_pos = 0;
				hit = 1'b0;
				hit_at = 0;
				ovf_seen = 1'b0;
			end
			default: ;
		endcase
	endtask

	// one random search: needle, haystack with an optional planted copy, finish
	task automatic gen_search();
		text_t ndl_b;
		text_t hay_b;
		logic [7:0] alpha[4];
		int n_alpha;
		int nlen;
		int hlen;
		int at;
		int roll;
		bit wild;
		ndl_b = {};
		hay_b = {};
		n_alpha = $urandom_range(2, 4);
		foreach (alpha[i])
			alpha[i] = 8'($urandom);
		wild = ($urandom_range(0, 9) == 0);
		roll = $urandom_range(0, 99);
		if (roll < 5)
			nlen = 0;
		else if (roll < 10)
			nlen = $urandom_range(MAX_NEEDLE - 4, MAX_NEEDLE + 4);
		else if (roll < 25)
			nlen = $urandom_range(7, 20);
		else
			nlen = $urandom_range(1, 6);
		for (int i = 0; i < nlen; i++)
			ndl_b.push_back(pick_char(alpha, n_alpha, wild));
		if ($urandom_range(0, 99) < 5)
			hlen = 0;
		else
			hlen = $urandom_range(1, 30) + ((nlen > 20) ? nlen : 0);
		for (int i = 0; i < hlen; i++)
			hay_b.push_back(pick_char(alpha, n_alpha, wild));
		// plant the needle so that most searches can hit
		if (nlen > 0 && nlen <= MAX_NEEDLE && hlen >= nlen && $urandom_range(0, 9) < 6) begin
			at = $urandom_range(0, hlen - nlen);
			for (int j = 0; j < nlen; j++)
				hay_b[at + j] = ndl_b[j];
		end
		foreach (ndl_b[i]) begin
			if ($urandom_range(0, 29) == 0)
				put(REQ_UNUSED, 8'($urandom));
			put(REQ_APPEND, ndl_b[i]);
		end
		foreach (hay_b[i]) begin
			if ($urandom_range(0, 29) == 0)
				put(REQ_UNUSED, 8'($urandom));
			put(REQ_HAY, hay_b[i]);
			// late needle byte, must be ignored
			if ($urandom_range(0, 19) == 0)
				put(REQ_APPEND, 8'($urandom));
		end
		put(REQ_FINISH, 8'($urandom));
		if ($urandom_range(0, 29) == 0)
			put(REQ_FINISH, 8'($urandom));
	endtask

	// driver: sends queued beats, predicts on every accepted beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			req_type <= REQ_APPEND;
			char_byte <= 8'h00;
		end else if (!in_valid || in_ready) begin
			if (in_valid) begin
				search_step(cur);
				beats_in++;
				if (beats_in % 128 == 0)
					idle_pct = pick_idle_pct();
			end
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (stim_beats.size() == 0) begin
				in_valid <= 1'b0;
			end else if (!calm && $urandom_range(0, 99) < idle_pct) begin
				gap_left = $urandom_range(0, 12);
				in_valid <= 1'b0;
			end else begin
				cur = stim_beats.pop_front();
				calm = (stim_beats.size() < CALM_TAIL);
				in_valid <= 1'b1;
				req_type <= cur.kind;
				char_byte <= cur.ch;
			end
		end
	end

	// monitor: checks each result beat, drives out_ready with stalls and one long hold
	always @(posedge clk or negedge arst_n) begin
		search_result_t e;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			mon_cycles++;
			if (mon_cycles % 300 == 0)
				stall_pct = pick_idle_pct();
			if (out_valid && out_ready) begin
				results_seen++;
				if (want_results.size() == 0) begin
					n_err++;
					if (n_err <= 10)
						$display("unexpected result: status %0d index %0d",
							status, match_index);
				end else begin
					e = want_results.pop_front();
					if (status !== e.st || match_index !== e.idx) begin
						n_err++;
						if (n_err <= 10)
							$display("result %0d: status exp %0d got %0d, index exp %0d got %0d",
								results_seen, e.st, status, e.idx, match_index);
					end
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (!hold_done && results_seen >= HOLD_AFTER) begin
				// long hold so the output register fills and the input backs up
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
				stall_left = $urandom_range(0, 12);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// watchdog on cycles without any accepted beat
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet = 0;
			end else begin
				quiet++;
				if (quiet >= QUIET_LIMIT) begin
					$display("CHECKS FAILED");
					$finish;
				end
			end
		end
	end

	initial begin
		int total_beats;
		int base;

		// empty cases: nothing, needle only, haystack only
		put(REQ_FINISH, 8'hFF);
		put(REQ_APPEND, 8'h00);
		put(REQ_FINISH, 8'h00);
		put(REQ_HAY, 8'hFF);
		put(REQ_FINISH, 8'h5A);
		// extreme bytes, finish right behind the completing byte
		put(REQ_APPEND, 8'h00);
		put(REQ_APPEND, 8'hFF);
		put(REQ_HAY, 8'h00);
		put(REQ_HAY, 8'hFF);
		put(REQ_FINISH, 8'hA5);
		// not found, with an unused request code in the middle
		put(REQ_APPEND, 8'hA5);
		put(REQ_HAY, 8'h5A);
		put(REQ_UNUSED, 8'h77);
		put(REQ_HAY, 8'h5A);
		put(REQ_FINISH, 8'h00);
		// overlapping prefix, locked needle, later match keeps first index
		put(REQ_APPEND, "a");
		put(REQ_APPEND, "a");
		put(REQ_APPEND, "b");
		put(REQ_HAY, "a");
		put(REQ_HAY, "a");
		put(REQ_HAY, "a");
		put(REQ_HAY, "b");
		put(REQ_APPEND, "c");
		put(REQ_HAY, "a");
		put(REQ_HAY, "a");
		put(REQ_HAY, "b");
		put(REQ_FINISH, 8'h00);
		// full needle matched at offset 3
		for (int i = 0; i < MAX_NEEDLE; i++)
			put(REQ_APPEND, 8'($urandom));
		for (int i = 0; i < 3; i++)
			put(REQ_HAY, 8'($urandom));
		for (int i = 0; i < MAX_NEEDLE; i++)
			put(REQ_HAY, stim_beats[stim_beats.size() - 3 - MAX_NEEDLE].ch);
		put(REQ_FINISH, 8'h00);
		// needle full, overflow wins over empty haystack
		for (int i = 0; i <= MAX_NEEDLE; i++)
			put(REQ_APPEND, 8'($urandom));
		put(REQ_FINISH, 8'h00);

		base = made_beats;
		while (made_beats - base < RANDOM_BEATS)
			gen_search();
		total_beats = stim_beats.size();

		idle_pct = pick_idle_pct();
		stall_pct = pick_idle_pct();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (beats_in < total_beats)
			@(negedge clk);
		while (want_results.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);

		if (n_err == 0 && want_results.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

[sim.f]
+incdir+sv
sv/sfms_pkg.sv
sv/sfms_cell.sv
sv/sfms_chain.sv
sv/substring_first_match_search_top.sv
tb/tb_substring_first_match_search_top.sv
